// ===== design/iba_pkg.sv =====
// Package for the IMU bias calibrator: widths, codes and control types.
`default_nettype none
package iba_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DEFAULT_COUNT   = 1000;
  localparam int NUM_AXES        = 6;
  localparam int RAW_W           = 16;
  localparam int OUT_W           = 17;
  localparam int AXIS_W          = $clog2(NUM_AXES);
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  // request codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // phase codes on the result channel
  localparam logic [1:0] PHASE_CALIB = 2'd0;
  localparam logic [1:0] PHASE_LAST  = 2'd1;
  localparam logic [1:0] PHASE_CORR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE
  } iba_state_t;

  typedef struct packed {
    logic              take_sample;
    logic              restart;
    logic              div_load;
    logic              div_step;
    logic              div_store;
    logic [AXIS_W-1:0] axis;
  } iba_cmd_t;

  typedef struct packed {
    logic calibrating;
    logic last_sample;
    logic out_free;
  } iba_status_t;

endpackage
`default_nettype wire

// ===== design/iba_if.sv =====
// Sample and result channel interfaces of the IMU bias calibrator.
`default_nettype none
interface iba_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] accel_x_raw;
  logic signed [15:0] accel_y_raw;
  logic signed [15:0] accel_z_raw;
  logic signed [15:0] gyro_x_raw;
  logic signed [15:0] gyro_y_raw;
  logic signed [15:0] gyro_z_raw;

  modport source (
    output valid, req_type, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );
  modport sink (
    input  valid, req_type, accel_x_raw, accel_y_raw, accel_z_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

interface iba_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         phase;
  logic signed [16:0] accel_x_out;
  logic signed [16:0] accel_y_out;
  logic signed [16:0] accel_z_out;
  logic signed [16:0] gyro_x_out;
  logic signed [16:0] gyro_y_out;
  logic signed [16:0] gyro_z_out;

  modport source (
    output valid, phase, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out,
    input  ready
  );
  modport sink (
    input  valid, phase, accel_x_out, accel_y_out, accel_z_out,
           gyro_x_out, gyro_y_out, gyro_z_out,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/iba_ctrl.sv =====
// Controller: sample acceptance and sequencing of the six bias divisions.
`default_nettype none
module iba_ctrl #(
  parameter int COUNT_WIDTH = iba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                req_type,
  output logic                     in_ready,
  input  wire iba_pkg::iba_status_t status,
  output iba_pkg::iba_cmd_t        cmd
);

  localparam int MAG_W  = COUNT_WIDTH + 17;
  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  iba_pkg::iba_state_t          state, state_next;
  logic [iba_pkg::AXIS_W-1:0]   axis, axis_next;
  logic [STEP_W-1:0]            step, step_next;
  logic                         accept;

  // closed during reset so that no beat is taken and then dropped
  assign in_ready = !rst && (state == iba_pkg::ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iba_pkg::ST_IDLE;
      axis  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    step_next  = step;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      iba_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type == iba_pkg::REQ_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            cmd.take_sample = 1'b1;
            if (status.calibrating && status.last_sample) begin
              state_next = iba_pkg::ST_DIV_LOAD;
              axis_next  = '0;
            end
          end
        end
      end
      iba_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = iba_pkg::ST_DIV_STEP;
      end
      iba_pkg::ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (step == LAST_STEP) begin
          state_next = iba_pkg::ST_DIV_STORE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      iba_pkg::ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (axis == iba_pkg::LAST_AXIS) begin
          state_next = iba_pkg::ST_IDLE;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = iba_pkg::ST_DIV_LOAD;
        end
      end
      default: state_next = iba_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/iba_datapath.sv =====
// Datapath: sums, offsets, sample counter, shared bit-serial divider, result register.
`default_nettype none
module iba_datapath #(
  parameter int COUNT_WIDTH = iba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [COUNT_WIDTH-1:0]     cfg_data,
  input  wire logic signed [iba_pkg::RAW_W-1:0] raw [iba_pkg::NUM_AXES],
  input  wire iba_pkg::iba_cmd_t          cmd,
  output iba_pkg::iba_status_t            status,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_phase,
  output logic signed [iba_pkg::OUT_W-1:0] out_val [iba_pkg::NUM_AXES]
);

  localparam int SUM_W = COUNT_WIDTH + 17;
  localparam int MAG_W = SUM_W;
  localparam int CNT_MAX = (1 << COUNT_WIDTH) - 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET =
    COUNT_WIDTH'((iba_pkg::DEFAULT_COUNT > CNT_MAX) ? CNT_MAX : iba_pkg::DEFAULT_COUNT);
  localparam int NA = iba_pkg::NUM_AXES;
  localparam int RW = iba_pkg::RAW_W;
  localparam int OW = iba_pkg::OUT_W;

  logic signed [SUM_W-1:0] sums    [NA];
  logic signed [OW-1:0]    offsets [NA];
  logic [COUNT_WIDTH-1:0]  samples_taken;
  logic [COUNT_WIDTH-1:0]  sample_count;
  logic                    calibrating;
  logic [COUNT_WIDTH-1:0]  divisor;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [MAG_W-1:0]        quot;
  logic                    quot_neg;

  logic [COUNT_WIDTH:0]    taken_ext;
  logic [COUNT_WIDTH-1:0]  target;
  logic                    last_sample;
  logic signed [SUM_W-1:0] sel_sum;
  logic [MAG_W-1:0]        sel_mag;
  logic [COUNT_WIDTH:0]    shifted;
  logic [COUNT_WIDTH:0]    diff;
  logic                    fits;
  logic [OW-1:0]           q_trunc;
  logic signed [OW-1:0]    offset_new;

  assign taken_ext   = {1'b0, samples_taken} + 1'b1;
  assign target      = (sample_count == '0) ? COUNT_WIDTH'(1) : sample_count;
  assign last_sample = taken_ext >= {1'b0, target};

  assign status.calibrating = calibrating;
  assign status.last_sample = last_sample;
  assign status.out_free    = !out_valid || out_ready;

  // divider: restoring, one quotient bit per step over the sum magnitude
  assign sel_sum = sums[cmd.axis];
  assign sel_mag = sel_sum[SUM_W-1] ? MAG_W'(-sel_sum) : MAG_W'(sel_sum);
  assign shifted = {rem, quot[MAG_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};
  assign q_trunc = quot[OW-1:0];
  // offset is minus the mean: a negative sum gives a positive offset
  assign offset_new = quot_neg ? signed'(q_trunc) : signed'(OW'(-q_trunc));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_RESET;
    end else if (cfg_we) begin
      sample_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating   <= 1'b1;
      samples_taken <= '0;
      for (int i = 0; i < NA; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
      end
    end else if (cmd.restart) begin
      calibrating   <= 1'b1;
      samples_taken <= '0;
      for (int i = 0; i < NA; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
      end
    end else if (cmd.take_sample && calibrating) begin
      samples_taken <= taken_ext[COUNT_WIDTH-1:0];
      if (last_sample) begin
        calibrating <= 1'b0;
      end
      for (int i = 0; i < NA; i++) begin
        sums[i] <= sums[i] + {{(SUM_W-RW){raw[i][RW-1]}}, raw[i]};
      end
    end else if (cmd.div_store) begin
      offsets[cmd.axis] <= offset_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample && calibrating && last_sample) begin
      divisor <= taken_ext[COUNT_WIDTH-1:0];
    end
    if (cmd.div_load) begin
      rem      <= '0;
      quot     <= sel_mag;
      quot_neg <= sel_sum[SUM_W-1];
    end else if (cmd.div_step) begin
      rem  <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
      quot <= {quot[MAG_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      if (!calibrating) begin
        out_phase <= iba_pkg::PHASE_CORR;
      end else if (last_sample) begin
        out_phase <= iba_pkg::PHASE_LAST;
      end else begin
        out_phase <= iba_pkg::PHASE_CALIB;
      end
      for (int i = 0; i < NA; i++) begin
        out_val[i] <= {{(OW-RW){raw[i][RW-1]}}, raw[i]} + offsets[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/imu_bias_average_calibrator_top.sv =====
// IMU bias calibrator: averages resting samples per axis and removes that bias.
//
// samples: one beat per request. req_type sample carries six raw axis words;
//   req_type restart zeroes offsets, sums and the sample counter and restarts
//   calibration; it yields no result beat.
// results: one beat per sample: phase code plus each raw word plus its offset.
//   Results appear in the cycle after the sample beat, held in an output register;
//   with results.ready high and no division running, a sample can be taken each cycle.
// The sample that completes calibration (phase last) starts six restoring
//   divisions of each sum by the number of samples taken, sharing one divider
//   that yields one quotient bit a cycle; samples.ready stays low while the
//   offsets are formed.
// Stall: while a result beat waits unaccepted, samples.ready is low.
// cfg_we/cfg_data set sample_count; write it only while the block is idle.
// Reset (rst, synchronous): offsets and sums zero, calibration active,
//   sample_count 1000 (saturated to the counter width), no result pending.
`default_nettype none
module imu_bias_average_calibrator_top #(
  parameter int COUNT_WIDTH = iba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  iba_in_if.sink                      samples,
  iba_out_if.source                   results,
  input  wire logic                   cfg_we,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data
);

  iba_pkg::iba_cmd_t    cmd;
  iba_pkg::iba_status_t status;
  logic signed [iba_pkg::RAW_W-1:0] raw     [iba_pkg::NUM_AXES];
  logic signed [iba_pkg::OUT_W-1:0] out_val [iba_pkg::NUM_AXES];

  assign raw[0] = samples.accel_x_raw;
  assign raw[1] = samples.accel_y_raw;
  assign raw[2] = samples.accel_z_raw;
  assign raw[3] = samples.gyro_x_raw;
  assign raw[4] = samples.gyro_y_raw;
  assign raw[5] = samples.gyro_z_raw;

  assign results.accel_x_out = out_val[0];
  assign results.accel_y_out = out_val[1];
  assign results.accel_z_out = out_val[2];
  assign results.gyro_x_out  = out_val[3];
  assign results.gyro_y_out  = out_val[4];
  assign results.gyro_z_out  = out_val[5];

  iba_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .req_type (samples.req_type),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  iba_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .raw       (raw),
    .cmd       (cmd),
    .status    (status),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_phase (results.phase),
    .out_val   (out_val)
  );

  // no sample beat while a result is stalled
  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> (!results.valid || results.ready))
    else $error("sample accepted while result stalled");

  // every sample beat yields a result beat next cycle
  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && samples.req_type == iba_pkg::REQ_SAMPLE)
    |=> results.valid)
    else $error("sample produced no result");

  // a restart creates no result
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && samples.req_type == iba_pkg::REQ_RESTART
     && !results.valid) |=> !results.valid)
    else $error("restart produced a result");

  // the last calibration sample stalls the input while offsets are formed
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !$stable(results.valid) && results.phase == iba_pkg::PHASE_LAST)
    |-> !samples.ready)
    else $error("input open during bias division");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the IMU bias calibrator: directed table, then random calibration runs.
module tb_top;

  localparam int CW             = iba_pkg::COUNT_WIDTH_DEF;
  // offsets are formed by six serial divisions after the last calibration beat
  localparam int DIV_CYCLES     = iba_pkg::NUM_AXES * (CW + 19) + 16;
  localparam int WATCHDOG_LIMIT = 20 * DIV_CYCLES;
  localparam int RANDOM_ITEMS   = 1050;

  typedef logic [0:iba_pkg::NUM_AXES-1][iba_pkg::RAW_W-1:0] raw_words_t;
  typedef logic [0:iba_pkg::NUM_AXES-1][iba_pkg::OUT_W-1:0] out_words_t;

  typedef struct packed {
    logic [1:0] phase;
    out_words_t axis;
  } calib_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_RESTART,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [CW-1:0] cfg_val;
    raw_words_t  raw;
    logic        typed;
    logic [1:0]  phase;
    out_words_t  want;
  } dir_row_t;

  localparam raw_words_t RAW_MAX  = {iba_pkg::NUM_AXES{16'h7fff}};
  localparam raw_words_t RAW_MIN  = {iba_pkg::NUM_AXES{16'h8000}};
  localparam out_words_t WANT_MAX = {iba_pkg::NUM_AXES{17'h07fff}};
  localparam out_words_t WANT_MIN = {iba_pkg::NUM_AXES{17'h18000}};

  localparam int DIR_ROWS = 32;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // default count of 1000: words pass straight through
    '{ROW_SAMPLE, '0, RAW_MAX, 1'b1, iba_pkg::PHASE_CALIB, WANT_MAX},
    '{ROW_SAMPLE, '0, RAW_MIN, 1'b1, iba_pkg::PHASE_CALIB, WANT_MIN},
    '{ROW_RESTART, '0, {iba_pkg::NUM_AXES{16'h5a5a}}, 1'b0, iba_pkg::PHASE_CALIB, '0},
    // zero count behaves as one
    '{ROW_CFG, 16'd0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{16'd100, -16'sd100, 16'd7, -16'sd7, 16'h7fff, 16'h8000},
      1'b1, iba_pkg::PHASE_LAST,
      '{17'sd100, -17'sd100, 17'sd7, -17'sd7, 17'sd32767, -17'sd32768}},
    '{ROW_SAMPLE, '0, '0, 1'b1, iba_pkg::PHASE_CORR,
      '{-17'sd100, 17'sd100, -17'sd7, 17'sd7, -17'sd32767, 17'sd32768}},
    '{ROW_SAMPLE, '0, RAW_MIN, 1'b1, iba_pkg::PHASE_CORR,
      '{-17'sd32868, -17'sd32668, -17'sd32775, -17'sd32761, -17'sd65535, 17'sd0}},
    '{ROW_SAMPLE, '0, RAW_MAX, 1'b1, iba_pkg::PHASE_CORR,
      '{17'sd32667, 17'sd32867, 17'sd32760, 17'sd32774, 17'sd0, 17'sd65535}},
    '{ROW_RESTART, '0, {iba_pkg::NUM_AXES{16'ha5a5}}, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_CFG, 16'd1, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{-16'sd1, 16'd1, 16'd3, -16'sd3, 16'd12345, -16'sd12345},
      1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, RAW_MAX, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_RESTART, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    // mean of 2/3 and -2/3 must truncate toward zero
    '{ROW_CFG, 16'd3, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{16'd1, -16'sd1, 16'd2, -16'sd2, 16'd5, -16'sd5},
      1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{16'd1, -16'sd1, 16'd2, -16'sd2, 16'd5, -16'sd5},
      1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_RESTART, '0, RAW_MIN, 1'b0, iba_pkg::PHASE_CALIB, '0},
    // count lowered below the samples already taken mid-calibration
    '{ROW_CFG, 16'd10, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{16'd40, -16'sd40, 16'd1000, -16'sd1000, 16'd3, -16'sd3},
      1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '{-16'sd20, 16'd20, 16'd999, -16'sd999, 16'd4, -16'sd4},
      1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, RAW_MIN, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, RAW_MAX, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_CFG, 16'd2, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    // largest count: only the opening beats of a long calibration
    '{ROW_CFG, 16'hffff, '0, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_RESTART, '0, RAW_MAX, 1'b0, iba_pkg::PHASE_CALIB, '0},
    '{ROW_SAMPLE, '0, RAW_MAX, 1'b1, iba_pkg::PHASE_CALIB, WANT_MAX},
    '{ROW_SAMPLE, '0, RAW_MIN, 1'b1, iba_pkg::PHASE_CALIB, WANT_MIN},
    '{ROW_RESTART, '0, '0, 1'b0, iba_pkg::PHASE_CALIB, '0}
  };

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [CW-1:0] cfg_data;

  iba_in_if  sample_ch ();
  iba_out_if result_ch ();

  imu_bias_average_calibrator_top #(
    .COUNT_WIDTH(CW)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // predictor state
  longint                           axis_sum [iba_pkg::NUM_AXES];
  logic signed [iba_pkg::OUT_W-1:0] axis_bias [iba_pkg::NUM_AXES];
  logic [CW-1:0]                    taken_cnt;
  logic [CW-1:0]                    target_cnt;
  bit                               calib_active;

  calib_result_t corrected_q [$];
  int            fail_count;
  int            tx_idle_pct;
  int            rx_stall_pct;
  int            rand_items;
  int            stall_cycles;
  raw_words_t    rest_level;

  string axis_out_name [iba_pkg::NUM_AXES] = '{"accel_x_out", "accel_y_out",
                                               "accel_z_out", "gyro_x_out",
                                               "gyro_y_out", "gyro_z_out"};

  function automatic void restart_calibration();
    for (int a = 0; a < iba_pkg::NUM_AXES; a++) begin
      axis_sum[a]  = 0;
      axis_bias[a] = '0;
    end
    taken_cnt    = '0;
    calib_active = 1'b1;
  endfunction

  function automatic calib_result_t correct_sample(raw_words_t raw);
    calib_result_t r;
    longint        taken;
    longint        target;
    for (int a = 0; a < iba_pkg::NUM_AXES; a++)
      r.axis[a] = iba_pkg::OUT_W'(longint'($signed(raw[a])) + longint'(axis_bias[a]));
    if (!calib_active) begin
      r.phase = iba_pkg::PHASE_CORR;
    end else begin
      for (int a = 0; a < iba_pkg::NUM_AXES; a++)
        axis_sum[a] += longint'($signed(raw[a]));
      taken     = longint'(taken_cnt) + 1;
      target    = (target_cnt == 0) ? 1 : longint'(target_cnt);
      taken_cnt = CW'(taken);
      if (taken >= target) begin
        // offsets take effect from the next beat on
        for (int a = 0; a < iba_pkg::NUM_AXES; a++)
          axis_bias[a] = iba_pkg::OUT_W'(-(axis_sum[a] / taken));
        calib_active = 1'b0;
        r.phase      = iba_pkg::PHASE_LAST;
      end else begin
        r.phase = iba_pkg::PHASE_CALIB;
      end
    end
    return r;
  endfunction

  function automatic raw_words_t rand_sample();
    raw_words_t w;
    for (int a = 0; a < iba_pkg::NUM_AXES; a++) begin
      case ($urandom_range(0, 9))
        0: w[a] = 16'h8000;
        1: w[a] = 16'h7fff;
        2, 3: w[a] = 16'($urandom);
        default: w[a] = rest_level[a] + 16'($urandom_range(0, 128)) - 16'd64;
      endcase
    end
    return w;
  endfunction

  function automatic void set_idling();
    if (rand_items < RANDOM_ITEMS / 3) begin
      tx_idle_pct  = 10;
      rx_stall_pct = 68;
    end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
      tx_idle_pct  = 68;
      rx_stall_pct = 10;
    end else begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end
  endfunction

  task automatic send_beat(input logic req, input raw_words_t raw,
                           input bit typed = 1'b0, input calib_result_t typed_res = '0);
    calib_result_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.req_type    <= req;
    sample_ch.accel_x_raw <= raw[0];
    sample_ch.accel_y_raw <= raw[1];
    sample_ch.accel_z_raw <= raw[2];
    sample_ch.gyro_x_raw  <= raw[3];
    sample_ch.gyro_y_raw  <= raw[4];
    sample_ch.gyro_z_raw  <= raw[5];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (req == iba_pkg::REQ_RESTART) begin
      restart_calibration();
    end else begin
      pred = correct_sample(raw);
      corrected_q.push_back(typed ? typed_res : pred);
    end
  endtask

  // drain all results, then allow for the division pass or a restart in flight
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (DIV_CYCLES) @(posedge clk);
  endtask

  task automatic write_sample_count(input logic [CW-1:0] count);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we     <= 1'b0;
    target_cnt = count;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    calib_result_t got;
    calib_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.phase, result_ch.accel_x_out, result_ch.accel_y_out,
             result_ch.accel_z_out, result_ch.gyro_x_out, result_ch.gyro_y_out,
             result_ch.gyro_z_out};
      if (corrected_q.size() == 0) begin
        $error("unexpected result beat: phase %0d", got.phase);
        fail_count++;
      end else begin
        want = corrected_q.pop_front();
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          fail_count++;
        end
        for (int a = 0; a < iba_pkg::NUM_AXES; a++) begin
          if (got.axis[a] !== want.axis[a]) begin
            $error("%s: expected %0d, got %0d", axis_out_name[a],
                   $signed(want.axis[a]), $signed(got.axis[a]));
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat or register write
  always @(posedge clk) begin
    if (rst || cfg_we || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("imu_bias_average_calibrator_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CW-1:0] new_count;
    int            seq_len;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.req_type    = iba_pkg::REQ_SAMPLE;
    sample_ch.accel_x_raw = '0;
    sample_ch.accel_y_raw = '0;
    sample_ch.accel_z_raw = '0;
    sample_ch.gyro_x_raw  = '0;
    sample_ch.gyro_y_raw  = '0;
    sample_ch.gyro_z_raw  = '0;
    fail_count            = 0;
    stall_cycles          = 0;
    rand_items            = 0;
    rest_level            = '0;
    target_cnt            = CW'(iba_pkg::DEFAULT_COUNT);
    restart_calibration();
    set_idling();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[i]) begin
      case (DIR_TABLE[i].kind)
        ROW_CFG:     write_sample_count(DIR_TABLE[i].cfg_val);
        ROW_RESTART: send_beat(iba_pkg::REQ_RESTART, DIR_TABLE[i].raw);
        default:     send_beat(iba_pkg::REQ_SAMPLE, DIR_TABLE[i].raw, DIR_TABLE[i].typed,
                               {DIR_TABLE[i].phase, DIR_TABLE[i].want});
      endcase
    end

    // random calibration runs: restart, calibrate around a resting level, correct
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       new_count = '0;
        1:       new_count = '1;
        2, 3:    new_count = CW'($urandom_range(20, 120));
        default: new_count = CW'($urandom_range(1, 12));
      endcase
      write_sample_count(new_count);
      for (int a = 0; a < iba_pkg::NUM_AXES; a++)
        rest_level[a] = 16'($urandom);
      set_idling();
      send_beat(iba_pkg::REQ_RESTART, rand_sample());
      rand_items++;
      if (new_count == '1)
        seq_len = $urandom_range(3, 20);
      else
        seq_len = ((new_count == 0) ? 1 : int'(new_count)) + $urandom_range(1, 15);
      for (int k = 0; k < seq_len; k++) begin
        set_idling();
        if ($urandom_range(0, 29) == 0)
          send_beat(iba_pkg::REQ_RESTART, rand_sample());
        else
          send_beat(iba_pkg::REQ_SAMPLE, rand_sample());
        rand_items++;
        if ($urandom_range(0, 59) == 0) begin
          if (calib_active && $urandom_range(0, 1) == 1)
            write_sample_count(CW'($urandom_range(0, 12)));
          else
            wait_idle();
        end
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("imu_bias_average_calibrator_top verification clean");
    else
      $display("imu_bias_average_calibrator_top verification failed");
    $finish;
  end

endmodule

// ===== imu_bias_average_calibrator_top.f =====
design/iba_pkg.sv
design/iba_if.sv
design/iba_ctrl.sv
design/iba_datapath.sv
design/imu_bias_average_calibrator_top.sv
verif/tb_top.sv
